### src/cep_pkg.sv
// Shared constants and helpers for the circle event priority core.
`default_nettype none
package cep_pkg;

  localparam int CEP_COORD_BITS = 32;
  localparam int CEP_LIMB       = 32;
  localparam int CEP_USER_DEG   = 0;
  localparam int CEP_USER_OVF   = 1;
  localparam int CEP_USER_W     = 2;

  function automatic int mul_lat(int w);
    return (w + CEP_LIMB - 1) / CEP_LIMB;
  endfunction

  function automatic int pad8(int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage
`default_nettype wire

### src/cep_mul.sv
// Pipelined unsigned multiplier, one operand limb per stage.
`default_nettype none
module cep_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  import cep_pkg::*;

  localparam int NA  = mul_lat(AW);
  localparam int NB  = mul_lat(BW);
  localparam int AXW = CEP_LIMB * NA;
  localparam int BXW = CEP_LIMB * NB;
  localparam int XW  = CEP_LIMB * (NA + NB);

  logic [AXW-1:0] a_st   [0:NA-1];
  logic [BXW-1:0] b_st   [0:NA-1];
  logic [XW-1:0]  acc_st [0:NA];
  logic [XW-1:0]  acc_r  [1:NA];

  assign a_st[0]   = AXW'(a);
  assign b_st[0]   = BXW'(b);
  assign acc_st[0] = '0;

  for (genvar k = 0; k < NA; k++) begin : g_row
    logic [XW-1:0] ev;
    logic [XW-1:0] od;

    always_comb begin
      ev = '0;
      od = '0;
      for (int j = 0; j < NB; j++) begin
        if (j[0] == 1'b0) begin
          ev[CEP_LIMB*(k+j) +: 2*CEP_LIMB] =
            a_st[k][CEP_LIMB*k +: CEP_LIMB] * b_st[k][CEP_LIMB*j +: CEP_LIMB];
        end else begin
          od[CEP_LIMB*(k+j) +: 2*CEP_LIMB] =
            a_st[k][CEP_LIMB*k +: CEP_LIMB] * b_st[k][CEP_LIMB*j +: CEP_LIMB];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k+1] <= acc_st[k] + ev + od;
      end
    end
    assign acc_st[k+1] = acc_r[k+1];

    if (k + 1 < NA) begin : g_fwd
      logic [AXW-1:0] a_r;
      logic [BXW-1:0] b_r;
      always_ff @(posedge clk) begin
        if (en) begin
          a_r <= a_st[k];
          b_r <= b_st[k];
        end
      end
      assign a_st[k+1] = a_r;
      assign b_st[k+1] = b_r;
    end
  end

  assign p = acc_st[NA][AW+BW-1:0];

endmodule
`default_nettype wire

### src/circle_event_priority_core.sv
// Circle event priority core: circumcenter y plus radius of three sites, pipelined.
// Takes one word of three sites per cycle while the output is not stalled, and
// returns one result word per site word, in order. The pipeline depth is set mostly
// by the square root and divider, which resolve one result bit per pipeline stage;
// the products use 32x32 partial products, one operand limb per stage. A stall on
// the output holds the whole pipeline; in_tready follows out_tready and the output
// register.
`default_nettype none
module circle_event_priority_core #(
  parameter int COORD_BITS = cep_pkg::CEP_COORD_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // site_a_x, site_a_y, site_b_x, site_b_y, site_c_x, site_c_y
  input  logic [cep_pkg::pad8(6*COORD_BITS)-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // event_y
  output logic [cep_pkg::pad8(COORD_BITS)-1:0] out_tdata,
  // degenerate, overflow
  output logic [cep_pkg::CEP_USER_W-1:0] out_tuser
);
  import cep_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int OUT_TW = pad8(CW);
  localparam int PW1   = 2*CW;
  localparam int UUW   = 2*CW + 1;
  localparam int PW2   = CW + UUW;
  localparam int DSW   = 2*CW + 2;
  localparam int DMW   = 2*CW + 1;
  localparam int DVW   = 2*CW + 2;
  localparam int NSW   = 3*CW + 3;
  localparam int NMW   = 3*CW + 2;
  localparam int RW    = 2*NMW + 2;
  localparam int SW    = NMW + 1;
  localparam int RMW   = SW + 2;
  localparam int QW    = 3*CW + 4;
  localparam int L1    = mul_lat(CW);
  localparam int L2    = mul_lat(CW);
  localparam int L3    = mul_lat(NMW);
  localparam int SD1   = 4 + 5*CW;
  localparam int SD2   = 4 + DSW + CW;
  localparam int SD3   = 1 + DMW + NSW + CW;
  localparam int SD5   = 1 + CW;
  localparam int LT    = 1 + L1 + 1 + L2 + 1 + 1 + L3 + 1 + SW + 1 + QW + 1;

  logic          en;
  logic          in_fire;
  logic [LT:1]   vld_r;

  assign en         = !vld_r[LT] || out_tready;
  assign in_tready  = en;
  assign in_fire    = in_tvalid && en;
  assign out_tvalid = vld_r[LT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LT-1:1], in_fire};
    end
  end

  // differences and magnitudes
  logic [CW-1:0]   site_a_x, site_a_y, site_b_x, site_b_y, site_c_x, site_c_y;
  logic signed [CW:0] dux, duy, dvx, dvy;
  logic [CW-1:0]   ux_r, uy_r, vx_r, vy_r, ay1_r;
  logic [3:0]      sg1_r;

  assign site_a_x = in_tdata[0*CW +: CW];
  assign site_a_y = in_tdata[1*CW +: CW];
  assign site_b_x = in_tdata[2*CW +: CW];
  assign site_b_y = in_tdata[3*CW +: CW];
  assign site_c_x = in_tdata[4*CW +: CW];
  assign site_c_y = in_tdata[5*CW +: CW];

  assign dux = $signed({site_b_x[CW-1], site_b_x}) - $signed({site_a_x[CW-1], site_a_x});
  assign duy = $signed({site_b_y[CW-1], site_b_y}) - $signed({site_a_y[CW-1], site_a_y});
  assign dvx = $signed({site_c_x[CW-1], site_c_x}) - $signed({site_a_x[CW-1], site_a_x});
  assign dvy = $signed({site_c_y[CW-1], site_c_y}) - $signed({site_a_y[CW-1], site_a_y});

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r  <= dux[CW] ? CW'(-dux) : dux[CW-1:0];
      uy_r  <= duy[CW] ? CW'(-duy) : duy[CW-1:0];
      vx_r  <= dvx[CW] ? CW'(-dvx) : dvx[CW-1:0];
      vy_r  <= dvy[CW] ? CW'(-dvy) : dvy[CW-1:0];
      sg1_r <= {dux[CW], duy[CW], dvx[CW], dvy[CW]};
      ay1_r <= site_a_y;
    end
  end

  // squares and cross terms
  logic [PW1-1:0] p_uxux, p_uyuy, p_vxvx, p_vyvy, p_uxvy, p_uyvx;

  cep_mul #(.AW(CW), .BW(CW)) u_m_uxux (.clk, .en, .a(ux_r), .b(ux_r), .p(p_uxux));
  cep_mul #(.AW(CW), .BW(CW)) u_m_uyuy (.clk, .en, .a(uy_r), .b(uy_r), .p(p_uyuy));
  cep_mul #(.AW(CW), .BW(CW)) u_m_vxvx (.clk, .en, .a(vx_r), .b(vx_r), .p(p_vxvx));
  cep_mul #(.AW(CW), .BW(CW)) u_m_vyvy (.clk, .en, .a(vy_r), .b(vy_r), .p(p_vyvy));
  cep_mul #(.AW(CW), .BW(CW)) u_m_uxvy (.clk, .en, .a(ux_r), .b(vy_r), .p(p_uxvy));
  cep_mul #(.AW(CW), .BW(CW)) u_m_uyvx (.clk, .en, .a(uy_r), .b(vx_r), .p(p_uyvx));

  logic [SD1-1:0] sd1_r [1:L1];
  logic [SD1-1:0] sd1_o;

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r[1] <= {sg1_r, ux_r, uy_r, vx_r, vy_r, ay1_r};
      for (int k = 2; k <= L1; k++) begin
        sd1_r[k] <= sd1_r[k-1];
      end
    end
  end
  assign sd1_o = sd1_r[L1];

  logic signed [DSW-1:0] t1, t2;
  logic [3:0]      sg_a_r;
  logic [CW-1:0]   ux_a_r, uy_a_r, vx_a_r, vy_a_r, ay_a_r;
  logic [UUW-1:0]  uu_r, vv_r;
  logic signed [DSW-1:0] d_a_r;

  assign t1 = (sd1_o[5*CW+3] ^ sd1_o[5*CW]) ? -$signed({2'b00, p_uxvy})
                                             : $signed({2'b00, p_uxvy});
  assign t2 = (sd1_o[5*CW+2] ^ sd1_o[5*CW+1]) ? -$signed({2'b00, p_uyvx})
                                               : $signed({2'b00, p_uyvx});

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r   <= UUW'(p_uxux) + UUW'(p_uyuy);
      vv_r   <= UUW'(p_vxvx) + UUW'(p_vyvy);
      d_a_r  <= t1 - t2;
      sg_a_r <= sd1_o[5*CW +: 4];
      ux_a_r <= sd1_o[4*CW +: CW];
      uy_a_r <= sd1_o[3*CW +: CW];
      vx_a_r <= sd1_o[2*CW +: CW];
      vy_a_r <= sd1_o[1*CW +: CW];
      ay_a_r <= sd1_o[0 +: CW];
    end
  end

  // numerator products
  logic [PW2-1:0] p_vyuu, p_uyvv, p_uxvv, p_vxuu;

  cep_mul #(.AW(CW), .BW(UUW)) u_m_vyuu (.clk, .en, .a(vy_a_r), .b(uu_r), .p(p_vyuu));
  cep_mul #(.AW(CW), .BW(UUW)) u_m_uyvv (.clk, .en, .a(uy_a_r), .b(vv_r), .p(p_uyvv));
  cep_mul #(.AW(CW), .BW(UUW)) u_m_uxvv (.clk, .en, .a(ux_a_r), .b(vv_r), .p(p_uxvv));
  cep_mul #(.AW(CW), .BW(UUW)) u_m_vxuu (.clk, .en, .a(vx_a_r), .b(uu_r), .p(p_vxuu));

  logic [SD2-1:0] sd2_r [1:L2];
  logic [SD2-1:0] sd2_o;

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r[1] <= {sg_a_r, d_a_r, ay_a_r};
      for (int k = 2; k <= L2; k++) begin
        sd2_r[k] <= sd2_r[k-1];
      end
    end
  end
  assign sd2_o = sd2_r[L2];

  logic signed [NSW-1:0] q1, q2, q3, q4;
  logic signed [NSW-1:0] nx_r, ny_r;
  logic signed [DSW-1:0] d_b_r;
  logic [CW-1:0]         ay_b_r;

  assign q1 = sd2_o[SD2-4] ? -$signed({2'b00, p_vyuu}) : $signed({2'b00, p_vyuu});
  assign q2 = sd2_o[SD2-2] ? -$signed({2'b00, p_uyvv}) : $signed({2'b00, p_uyvv});
  assign q3 = sd2_o[SD2-1] ? -$signed({2'b00, p_uxvv}) : $signed({2'b00, p_uxvv});
  assign q4 = sd2_o[SD2-3] ? -$signed({2'b00, p_vxuu}) : $signed({2'b00, p_vxuu});

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= q1 - q2;
      ny_r   <= q3 - q4;
      d_b_r  <= $signed(sd2_o[CW +: DSW]);
      ay_b_r <= sd2_o[0 +: CW];
    end
  end

  // orient so the divisor is positive, take magnitudes
  logic signed [NSW-1:0] nyf_r;
  logic [NMW-1:0]        nxm_r, nym_r;
  logic [DMW-1:0]        dm_r;
  logic                  deg_c_r;
  logic [CW-1:0]         ay_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nyf_r   <= d_b_r[DSW-1] ? -ny_r : ny_r;
      nxm_r   <= nx_r[NSW-1] ? NMW'(-nx_r) : nx_r[NMW-1:0];
      nym_r   <= ny_r[NSW-1] ? NMW'(-ny_r) : ny_r[NMW-1:0];
      dm_r    <= d_b_r[DSW-1] ? DMW'(-d_b_r) : d_b_r[DMW-1:0];
      deg_c_r <= (d_b_r == '0);
      ay_c_r  <= ay_b_r;
    end
  end

  logic [2*NMW-1:0] p_nx2, p_ny2;

  cep_mul #(.AW(NMW), .BW(NMW)) u_m_nx2 (.clk, .en, .a(nxm_r), .b(nxm_r), .p(p_nx2));
  cep_mul #(.AW(NMW), .BW(NMW)) u_m_ny2 (.clk, .en, .a(nym_r), .b(nym_r), .p(p_ny2));

  logic [SD3-1:0] sd3_r [1:L3];

  always_ff @(posedge clk) begin
    if (en) begin
      sd3_r[1] <= {deg_c_r, dm_r, nyf_r, ay_c_r};
      for (int k = 2; k <= L3; k++) begin
        sd3_r[k] <= sd3_r[k-1];
      end
    end
  end

  // square root, one root bit per stage
  logic [RW-1:0]  sq_rad_r  [0:SW];
  logic [RMW-1:0] sq_rem_r  [0:SW];
  logic [SW-1:0]  sq_root_r [0:SW];
  logic [SD3-1:0] sq_side_r [0:SW];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= RW'(p_nx2) + RW'(p_ny2);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_side_r[0] <= sd3_r[L3];
    end
  end

  for (genvar i = 1; i <= SW; i++) begin : g_sqrt
    logic [RMW+1:0] rx, trial, diff;
    logic           ge;

    assign rx    = {sq_rem_r[i-1], sq_rad_r[i-1][RW-1-2*(i-1) -: 2]};
    assign trial = {2'b00, sq_root_r[i-1], 2'b01};
    assign diff  = rx - trial;
    assign ge    = (rx >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[i]  <= sq_rad_r[i-1];
        sq_rem_r[i]  <= ge ? diff[RMW-1:0] : rx[RMW-1:0];
        sq_root_r[i] <= {sq_root_r[i-1][SW-2:0], ge};
        sq_side_r[i] <= sq_side_r[i-1];
      end
    end
  end

  // divide (ny + root) by 2|d|, one quotient bit per stage
  logic [SD3-1:0]        sq_o;
  logic signed [QW-1:0]  num;
  logic [QW-1:0]         dv_n_r    [0:QW];
  logic [DVW-1:0]        dv_d_r    [0:QW];
  logic [DVW-1:0]        dv_rem_r  [0:QW];
  logic [QW-1:0]         dv_q_r    [0:QW];
  logic [SD5-1:0]        dv_side_r [0:QW];

  assign sq_o = sq_side_r[SW];
  assign num  = $signed({sq_o[CW+NSW-1], sq_o[CW +: NSW]})
              + $signed({1'b0, sq_root_r[SW]});

  always_ff @(posedge clk) begin
    if (en) begin
      dv_n_r[0]    <= num;
      dv_d_r[0]    <= {sq_o[CW+NSW +: DMW], 1'b0};
      dv_rem_r[0]  <= '0;
      dv_q_r[0]    <= '0;
      dv_side_r[0] <= {sq_o[SD3-1], sq_o[0 +: CW]};
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_div
    logic [DVW:0] rx, diff;
    logic         ge;

    assign rx   = {dv_rem_r[i-1], dv_n_r[i-1][QW-i]};
    assign diff = rx - {1'b0, dv_d_r[i-1]};
    assign ge   = (rx >= {1'b0, dv_d_r[i-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        dv_n_r[i]    <= dv_n_r[i-1];
        dv_d_r[i]    <= dv_d_r[i-1];
        dv_rem_r[i]  <= ge ? diff[DVW-1:0] : rx[DVW-1:0];
        dv_q_r[i]    <= {dv_q_r[i-1][QW-2:0], ge};
        dv_side_r[i] <= dv_side_r[i-1];
      end
    end
  end

  // add a_y, saturate on overflow or clear if degenerate, register the result word
  logic [CW-1:0]         ay_o;
  logic                  deg_o;
  logic signed [QW+1:0]  sum;
  logic                  ovf;
  logic [CW-1:0]         out_y_r;
  logic                  out_deg_r, out_ovf_r;

  assign ay_o  = dv_side_r[QW][CW-1:0];
  assign deg_o = dv_side_r[QW][SD5-1];
  assign sum   = $signed({2'b00, dv_q_r[QW]})
               + $signed({{(QW+2-CW){ay_o[CW-1]}}, ay_o});
  assign ovf   = !deg_o && !sum[QW+1] && (sum[QW:CW-1] != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      out_deg_r <= deg_o;
      out_ovf_r <= ovf;
      if (deg_o) begin
        out_y_r <= '0;
      end else if (ovf) begin
        out_y_r <= {1'b0, {(CW-1){1'b1}}};
      end else begin
        out_y_r <= sum[CW-1:0];
      end
    end
  end

  assign out_tdata                = OUT_TW'(out_y_r);
  assign out_tuser[CEP_USER_DEG]  = out_deg_r;
  assign out_tuser[CEP_USER_OVF]  = out_ovf_r;

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_deg_r |-> out_y_r == '0 && !out_ovf_r)
    else $error("degenerate result not cleared");

  a_ovf_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_ovf_r |-> out_y_r == {1'b0, {(CW-1){1'b1}}})
    else $error("overflow result not saturated");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(vld_r) && $stable(out_y_r))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
